[rtl/core/tkcl_pkg.sv]
// ----------------------------------------------------------------------------
// tkcl_pkg
// Shared types, key codes and keypad zone bounds for the touch keypad lock.
// ----------------------------------------------------------------------------
`default_nettype none

package tkcl_pkg;

  localparam int unsigned CodeLengthDefault = 5;
  localparam int unsigned NumShownSlots     = 5;
  localparam int unsigned CodeWidth         = 20;
  localparam int unsigned DigitWidth        = 4;
  localparam int unsigned ApbAddrWidth      = 3;
  localparam int unsigned ApbDataWidth      = 32;

  typedef logic [DigitWidth-1:0] key_t;
  typedef logic [1:0]            status_t;

  localparam key_t KeyEmpty   = 4'd12;
  localparam key_t KeyNone    = 4'd12;
  localparam key_t KeyReturn  = 4'd13;
  localparam key_t KeyEnter   = 4'd14;
  localparam key_t KeyNoTouch = 4'd15;

  localparam status_t StUnknown = 2'd0;
  localparam status_t StCorrect = 2'd1;
  localparam status_t StWrong   = 2'd2;

  // register index on the configuration port
  localparam logic [ApbAddrWidth-3:0] RegSecretCode = '0;

  // keypad zones, all bounds exclusive
  localparam logic [7:0] Row0Lo = 8'd20;
  localparam logic [7:0] Row0Hi = 8'd45;
  localparam logic [7:0] Row1Lo = 8'd62;
  localparam logic [7:0] Row1Hi = 8'd87;
  localparam logic [7:0] Row2Lo = 8'd104;
  localparam logic [7:0] Row2Hi = 8'd129;
  localparam logic [7:0] Row3Lo = 8'd146;
  localparam logic [7:0] Row3Hi = 8'd170;
  localparam logic [7:0] Col0Lo = 8'd58;
  localparam logic [7:0] Col0Hi = 8'd95;
  localparam logic [7:0] Col1Lo = 8'd110;
  localparam logic [7:0] Col1Hi = 8'd148;
  localparam logic [7:0] Col2Lo = 8'd162;
  localparam logic [7:0] Col2Hi = 8'd199;
  localparam logic [7:0] FnColLo = 8'd226;
  localparam logic [7:0] FnColHi = 8'd251;

  typedef struct packed {
    logic [7:0] touch_x;
    logic [7:0] touch_y;
    logic       quit_key;
  } in_item_t;

  typedef struct packed {
    key_t    slot0;
    key_t    slot1;
    key_t    slot2;
    key_t    slot3;
    key_t    slot4;
    status_t status;
    key_t    key_code;
    logic    session_done;
  } out_item_t;

  // digit key at a keypad column and row
  function automatic key_t key_at(input logic [1:0] col, input logic [1:0] row);
    key_t k;
    k = KeyNone;
    case (col)
      2'd0: begin
        case (row)
          2'd0:    k = 4'd1;
          2'd1:    k = 4'd4;
          2'd2:    k = 4'd7;
          default: k = 4'd10;
        endcase
      end
      2'd1: begin
        case (row)
          2'd0:    k = 4'd2;
          2'd1:    k = 4'd5;
          2'd2:    k = 4'd8;
          default: k = 4'd0;
        endcase
      end
      2'd2: begin
        case (row)
          2'd0:    k = 4'd3;
          2'd1:    k = 4'd6;
          2'd2:    k = 4'd9;
          default: k = 4'd11;
        endcase
      end
      default: k = KeyNone;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[rtl/core/touch_keypad_code_lock_top.sv]
// ----------------------------------------------------------------------------
// touch_keypad_code_lock_top
// Decodes touch positions to keypad keys, collects code digits and checks
// them against the programmed secret code.
//
//   channel   direction  payload             handshake
//   in        input      tkcl_pkg::in_item_t  in_valid_i / in_ready_o
//   out       output     tkcl_pkg::out_item_t out_valid_o / out_ready_i
//   cfg       input      secret code (APB)    psel / penable / pready
//
// One result per request; it passes the input register, then the result register.
// A request can be taken every cycle; the input register and the result
// register each hold one request, so while a result waits one more request
// is taken, then input stalls until the result leaves.
// Decode, slot update and code compare sit between the two registers.
// Reset empties all slots, clears the status and the secret code.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_keypad_code_lock_top #(
  parameter int unsigned CODE_LENGTH = tkcl_pkg::CodeLengthDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire tkcl_pkg::in_item_t                  in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output tkcl_pkg::out_item_t                      out_data_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [tkcl_pkg::ApbAddrWidth-1:0]   paddr,
  input  wire logic [tkcl_pkg::ApbDataWidth-1:0]   pwdata,
  output logic [tkcl_pkg::ApbDataWidth-1:0]        prdata,
  output logic                                     pready
);

  localparam int unsigned CntW = $clog2(CODE_LENGTH + 1);
  localparam int unsigned ExtW = tkcl_pkg::DigitWidth * CODE_LENGTH;

  // configuration
  logic [tkcl_pkg::CodeWidth-1:0] code_q;
  logic                           cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[tkcl_pkg::ApbAddrWidth-1:2] == tkcl_pkg::RegSecretCode);
  assign prdata  = cfg_hit ? tkcl_pkg::ApbDataWidth'(code_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      code_q <= pwdata[tkcl_pkg::CodeWidth-1:0];
    end
  end

  // handshake and pipeline registers
  logic                in_valid_q;
  tkcl_pkg::in_item_t  in_q;
  logic                out_valid_q;
  tkcl_pkg::out_item_t out_q;
  logic                advance;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // key decode
  logic [1:0]          row;
  logic                row_hit;
  logic [1:0]          col;
  logic                col_hit;
  logic                fn_hit;
  logic                touched;
  tkcl_pkg::key_t      key;

  assign touched = (in_q.touch_x != 8'd0) || (in_q.touch_y != 8'd0);

  always_comb begin
    row     = 2'd0;
    row_hit = 1'b1;
    if (in_q.touch_y > tkcl_pkg::Row0Lo && in_q.touch_y < tkcl_pkg::Row0Hi) begin
      row = 2'd0;
    end else if (in_q.touch_y > tkcl_pkg::Row1Lo && in_q.touch_y < tkcl_pkg::Row1Hi) begin
      row = 2'd1;
    end else if (in_q.touch_y > tkcl_pkg::Row2Lo && in_q.touch_y < tkcl_pkg::Row2Hi) begin
      row = 2'd2;
    end else if (in_q.touch_y > tkcl_pkg::Row3Lo && in_q.touch_y < tkcl_pkg::Row3Hi) begin
      row = 2'd3;
    end else begin
      row_hit = 1'b0;
    end

    col     = 2'd0;
    col_hit = 1'b1;
    fn_hit  = 1'b0;
    if (in_q.touch_x > tkcl_pkg::Col0Lo && in_q.touch_x < tkcl_pkg::Col0Hi) begin
      col = 2'd0;
    end else if (in_q.touch_x > tkcl_pkg::Col1Lo && in_q.touch_x < tkcl_pkg::Col1Hi) begin
      col = 2'd1;
    end else if (in_q.touch_x > tkcl_pkg::Col2Lo && in_q.touch_x < tkcl_pkg::Col2Hi) begin
      col = 2'd2;
    end else begin
      col_hit = 1'b0;
      fn_hit  = (in_q.touch_x > tkcl_pkg::FnColLo) && (in_q.touch_x < tkcl_pkg::FnColHi);
    end

    if (!touched) begin
      key = tkcl_pkg::KeyNoTouch;
    end else if (col_hit && row_hit) begin
      key = tkcl_pkg::key_at(col, row);
    end else if (fn_hit && row_hit && row == 2'd1) begin
      key = tkcl_pkg::KeyReturn;
    end else if (fn_hit && row_hit && row == 2'd2) begin
      key = tkcl_pkg::KeyEnter;
    end else begin
      key = tkcl_pkg::KeyNone;
    end
  end

  // slot state
  logic [CODE_LENGTH-1:0][tkcl_pkg::DigitWidth-1:0] digits_q, digits_d;
  logic [CntW-1:0]                                   fill_q, fill_d;
  tkcl_pkg::status_t                                 status_q, status_d, status_res;
  logic [ExtW-1:0]                                   code_ext;
  logic                                              match;
  logic                                              done;
  logic [tkcl_pkg::NumShownSlots-1:0][tkcl_pkg::DigitWidth-1:0] shown;

  // code digits beyond the register read as zero
  assign code_ext = ExtW'(code_q);

  always_comb begin
    match = 1'b1;
    for (int unsigned i = 0; i < CODE_LENGTH; i++) begin
      if (digits_q[i] != code_ext[tkcl_pkg::DigitWidth*i +: tkcl_pkg::DigitWidth]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    digits_d   = digits_q;
    fill_d     = fill_q;
    status_res = status_q;
    if (key < tkcl_pkg::KeyNone) begin
      if (fill_q < CntW'(CODE_LENGTH)) begin
        for (int unsigned i = 0; i < CODE_LENGTH; i++) begin
          if (fill_q == CntW'(i)) begin
            digits_d[i] = key;
          end
        end
        fill_d = fill_q + CntW'(1);
      end
    end else if (key == tkcl_pkg::KeyReturn) begin
      if (fill_q != '0) begin
        for (int unsigned i = 0; i < CODE_LENGTH; i++) begin
          if (fill_q == CntW'(i + 1)) begin
            digits_d[i] = tkcl_pkg::KeyEmpty;
          end
        end
        fill_d     = fill_q - CntW'(1);
        status_res = tkcl_pkg::StUnknown;
      end
    end else if (key == tkcl_pkg::KeyEnter) begin
      status_res = match ? tkcl_pkg::StCorrect : tkcl_pkg::StWrong;
    end

    done = in_q.quit_key || (status_res == tkcl_pkg::StCorrect);
    if (done) begin
      for (int unsigned i = 0; i < CODE_LENGTH; i++) begin
        digits_d[i] = tkcl_pkg::KeyEmpty;
      end
      fill_d = '0;
    end
    status_d = done ? tkcl_pkg::StUnknown : status_res;
  end

  for (genvar j = 0; j < tkcl_pkg::NumShownSlots; j++) begin : g_shown
    if (j < CODE_LENGTH) begin : g_slot
      assign shown[j] = digits_d[j];
    end else begin : g_blank
      assign shown[j] = tkcl_pkg::KeyEmpty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fill_q      <= '0;
      status_q    <= tkcl_pkg::StUnknown;
      for (int unsigned i = 0; i < CODE_LENGTH; i++) begin
        digits_q[i] <= tkcl_pkg::KeyEmpty;
      end
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        fill_q      <= fill_d;
        status_q    <= status_d;
        digits_q    <= digits_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q.slot0        <= shown[0];
      out_q.slot1        <= shown[1];
      out_q.slot2        <= shown[2];
      out_q.slot3        <= shown[3];
      out_q.slot4        <= shown[4];
      out_q.status       <= status_res;
      out_q.key_code     <= key;
      out_q.session_done <= done;
    end
  end

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(CODE_LENGTH))
    else $error("fill count beyond code length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q != tkcl_pkg::StCorrect)
    else $error("correct status kept past session end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && done |=> fill_q == '0)
    else $error("slots not cleared at session end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.session_done |->
      out_q.slot0 == tkcl_pkg::KeyEmpty && out_q.slot1 == tkcl_pkg::KeyEmpty &&
      out_q.slot2 == tkcl_pkg::KeyEmpty && out_q.slot3 == tkcl_pkg::KeyEmpty &&
      out_q.slot4 == tkcl_pkg::KeyEmpty)
    else $error("ended session reports filled slots");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("empty input register refuses a request");

endmodule

`default_nettype wire
